@@ sv/hpq_pkg.sv @@
package hpq_pkg;

    // Default number of heap slots
    localparam int HPQ_CAPACITY = 64;

    // Key and reported count widths
    localparam int KEY_W        = 32;
    localparam int COUNT_PORT_W = 7;

    typedef logic signed [KEY_W-1:0] key_t;

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

endpackage

@@ sv/max_heap_priority_queue.sv @@
// Insert sifts the new key up from the new last slot; delete returns the root, moves the last
// entry to the root and sifts it down. Each level of sift is a read and a compare state, with
// at most log2(CAPACITY) swaps. A reject and a delete that empties the heap skip the sift.
// One item at a time: a new one is taken only in S_IDLE; a held result parks the next one in S_FIN.
// Reset empties the heap at once; the heap RAM is not cleared.
module max_heap_priority_queue
    import hpq_pkg::*;
#(
    parameter int CAPACITY = HPQ_CAPACITY
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    opcode,
    input  logic signed [KEY_W-1:0] value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [KEY_W-1:0] removed_value,
    output logic signed [KEY_W-1:0] top_value,
    output logic [COUNT_PORT_W-1:0] entry_count,
    output logic                    is_empty,
    output logic                    is_full,
    output logic                    rejected
);

    localparam int AW = $clog2(CAPACITY);
    localparam int IW = $clog2(CAPACITY + 1);
    localparam logic [IW-1:0] CAP_CNT = IW'(CAPACITY);
    localparam logic [IW-1:0] ONE_IDX = IW'(1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_INS_RD = 3'd1;
    localparam logic [2:0] S_INS_CM = 3'd2;
    localparam logic [2:0] S_DEL_LD = 3'd3;
    localparam logic [2:0] S_DN_RD  = 3'd4;
    localparam logic [2:0] S_DN_CM  = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;

    logic [2:0]    state_reg, state_next;
    logic [IW-1:0] count_reg, count_next;
    logic [IW-1:0] idx_reg, idx_next;
    key_t          key_reg, key_next;
    key_t          top_reg, top_next;
    key_t          removed_reg, removed_next;
    logic          rej_reg, rej_next;

    logic          out_valid_reg, out_valid_next;
    key_t          out_removed_reg;
    key_t          out_top_reg;
    logic [IW-1:0] out_count_reg;
    logic          out_empty_reg;
    logic          out_full_reg;
    logic          out_rej_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    key_t          ram_wdata;
    logic [AW-1:0] ram_raddr_a, ram_raddr_b;
    logic [KEY_W-1:0] ram_rdata_a, ram_rdata_b;
    key_t          child_l, child_r, big_val;

    logic [IW-1:0] idx_m1, parent_idx, parent_m1, count_m1;
    logic [IW:0]   left_idx, right_idx, left_m1, count_ext;
    logic          left_ok, right_ok;
    logic [IW+COUNT_PORT_W-1:0] count_wide;

    hpq_ram #(
        .WIDTH(KEY_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk    (clk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .raddr_a(ram_raddr_a),
        .rdata_a(ram_rdata_a),
        .raddr_b(ram_raddr_b),
        .rdata_b(ram_rdata_b)
    );

    // Index arithmetic for the current slot, its parent and its children
    assign idx_m1     = idx_reg - ONE_IDX;
    assign parent_idx = idx_reg >> 1;
    assign parent_m1  = parent_idx - ONE_IDX;
    assign count_m1   = count_reg - ONE_IDX;
    assign left_idx   = {idx_reg, 1'b0};
    assign right_idx  = {idx_reg, 1'b1};
    assign left_m1    = {idx_m1, 1'b1};
    assign count_ext  = {1'b0, count_reg};
    assign left_ok    = left_idx <= count_ext;
    assign right_ok   = right_idx <= count_ext;
    assign child_l    = key_t'(ram_rdata_a);
    assign child_r    = key_t'(ram_rdata_b);

    // Sequencer: one level of sift per read-compare pass
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        key_next       = key_reg;
        top_next       = top_reg;
        removed_next   = removed_reg;
        rej_next       = rej_reg;
        out_valid_next = out_valid_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_m1[AW-1:0];
        ram_wdata      = key_reg;
        ram_raddr_a    = parent_m1[AW-1:0];
        ram_raddr_b    = parent_m1[AW-1:0];
        big_val        = key_reg;

        // Drop the result beat once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    removed_next = '0;
                    rej_next     = 1'b0;
                    key_next     = value;
                    if (opcode == OP_INSERT)
                    begin
                        if (count_reg == CAP_CNT)
                        begin
                            rej_next   = 1'b1;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            count_next = count_reg + ONE_IDX;
                            idx_next   = count_reg + ONE_IDX;
                            state_next = S_INS_RD;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            rej_next   = 1'b1;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            // Fetch root and last entry together
                            ram_raddr_a = '0;
                            ram_raddr_b = count_m1[AW-1:0];
                            count_next  = count_m1;
                            idx_next    = ONE_IDX;
                            state_next  = S_DEL_LD;
                        end
                    end
                end
            end

            S_INS_RD:
            begin
                if (idx_reg == ONE_IDX)
                begin
                    ram_we     = 1'b1;
                    top_next   = key_reg;
                    state_next = S_FIN;
                end
                else
                begin
                    ram_raddr_a = parent_m1[AW-1:0];
                    state_next  = S_INS_CM;
                end
            end

            S_INS_CM:
            begin
                ram_we = 1'b1;
                if (key_reg > child_l)
                begin
                    // Pull the parent down into the hole
                    ram_wdata  = child_l;
                    idx_next   = parent_idx;
                    state_next = S_INS_RD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end

            S_DEL_LD:
            begin
                removed_next = child_l;
                key_next     = child_r;
                if (count_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_DN_RD;
                end
            end

            S_DN_RD:
            begin
                if (!left_ok)
                begin
                    ram_we     = 1'b1;
                    if (idx_reg == ONE_IDX)
                    begin
                        top_next = key_reg;
                    end
                    state_next = S_FIN;
                end
                else
                begin
                    ram_raddr_a = left_m1[AW-1:0];
                    ram_raddr_b = left_idx[AW-1:0];
                    state_next  = S_DN_CM;
                end
            end

            S_DN_CM:
            begin
                ram_we = 1'b1;
                if (child_l > key_reg)
                begin
                    big_val  = child_l;
                    idx_next = left_idx[IW-1:0];
                end
                if (right_ok && (child_r > big_val))
                begin
                    big_val  = child_r;
                    idx_next = right_idx[IW-1:0];
                end
                ram_wdata = big_val;
                if (idx_reg == ONE_IDX)
                begin
                    top_next = big_val;
                end
                if (idx_next == idx_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_DN_RD;
                end
            end

            S_FIN:
            begin
                // Park the result once the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working payload
    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        key_reg     <= key_next;
        top_reg     <= top_next;
        removed_reg <= removed_next;
        rej_reg     <= rej_next;
    end

    // Result payload, loaded as the result beat is formed
    always_ff @(posedge clk)
    begin
        if (state_reg == S_FIN && (!out_valid_reg || out_ready))
        begin
            out_removed_reg <= removed_reg;
            out_top_reg     <= (count_reg == '0) ? key_t'(0) : top_reg;
            out_count_reg   <= count_reg;
            out_empty_reg   <= (count_reg == '0);
            out_full_reg    <= (count_reg == CAP_CNT);
            out_rej_reg     <= rej_reg;
        end
    end

    assign count_wide    = {{COUNT_PORT_W{1'b0}}, out_count_reg};

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign removed_value = out_removed_reg;
    assign top_value     = out_top_reg;
    assign entry_count   = count_wide[COUNT_PORT_W-1:0];
    assign is_empty      = out_empty_reg;
    assign is_full       = out_full_reg;
    assign rejected      = out_rej_reg;

endmodule

@@ sv/hpq_ram.sv @@
module hpq_ram
    import hpq_pkg::*;
#(
    parameter int WIDTH = KEY_W,
    parameter int DEPTH = HPQ_CAPACITY
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read two with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ bench/tb_top.sv @@
module tb_top;
    import hpq_pkg::*;

    localparam int TOTAL_ITEMS  = 1550;
    localparam int IDLE_PCT     = 27;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int SETTLE_CYCLES = 32;
    localparam int HOLD_AT      = 300;
    localparam int PAUSE_AT     = 700;
    localparam int STEADY_FROM  = 900;
    localparam int STEADY_TO    = 1150;
    localparam int DIR_N        = 23;

    localparam key_t KEY_MAX = 32'h7FFF_FFFF;
    localparam key_t KEY_MIN = 32'h8000_0000;

    typedef struct packed {
        key_t                    removed;
        key_t                    top;
        logic [COUNT_PORT_W-1:0] count;
        logic                    empty;
        logic                    full;
        logic                    rej;
    } heap_status_t;

    typedef struct packed {
        logic         op;
        key_t         key;
        logic         typed;
        heap_status_t want;
    } dir_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic                    opcode;
    key_t                    value;
    logic                    out_valid;
    logic                    out_ready;
    key_t                    removed_value;
    key_t                    top_value;
    logic [COUNT_PORT_W-1:0] entry_count;
    logic                    is_empty;
    logic                    is_full;
    logic                    rejected;

    // Shadow heap and pending results
    key_t         shadow_keys [1:HPQ_CAPACITY];
    int           shadow_fill;
    heap_status_t pending_status [$];

    int  mismatch_cnt;
    int  n_sent;
    int  n_checked;
    int  n_rejects;
    int  n_full_seen;
    int  n_deletes;
    int  stall_cnt;
    bit  hold_req;
    bit  steady;

    dir_row_t dir_rows [DIR_N];

    max_heap_priority_queue i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .removed_value(removed_value),
        .top_value    (top_value),
        .entry_count  (entry_count),
        .is_empty     (is_empty),
        .is_full      (is_full),
        .rejected     (rejected)
    );

    always #2 clk = ~clk;

    // Apply one operation to the shadow heap and return the status it reports
    function automatic heap_status_t heap_apply(input logic op, input key_t key);
        heap_status_t st;
        int           idx;
        int           up;
        int           lc;
        int           rc;
        int           big;
        key_t         tmp;
        st = '0;
        if (op == OP_INSERT) begin
            if (shadow_fill >= HPQ_CAPACITY) begin
                st.rej = 1'b1;
            end
            else begin
                shadow_fill++;
                shadow_keys[shadow_fill] = key;
                idx = shadow_fill;
                // sift up while the parent is strictly smaller
                while (idx > 1) begin
                    up = idx / 2;
                    if (shadow_keys[idx] > shadow_keys[up]) begin
                        tmp = shadow_keys[up];
                        shadow_keys[up] = shadow_keys[idx];
                        shadow_keys[idx] = tmp;
                        idx = up;
                    end
                    else begin
                        break;
                    end
                end
            end
        end
        else begin
            if (shadow_fill == 0) begin
                st.rej = 1'b1;
            end
            else begin
                st.removed = shadow_keys[1];
                shadow_keys[1] = shadow_keys[shadow_fill];
                shadow_fill--;
                idx = 1;
                // sift down toward the larger child, left wins a tie
                while (idx <= shadow_fill) begin
                    lc = 2 * idx;
                    rc = lc + 1;
                    big = idx;
                    if (lc <= shadow_fill && shadow_keys[lc] > shadow_keys[big])
                        big = lc;
                    if (rc <= shadow_fill && shadow_keys[rc] > shadow_keys[big])
                        big = rc;
                    if (big == idx)
                        break;
                    tmp = shadow_keys[big];
                    shadow_keys[big] = shadow_keys[idx];
                    shadow_keys[idx] = tmp;
                    idx = big;
                end
            end
        end
        st.top   = (shadow_fill != 0) ? shadow_keys[1] : '0;
        st.count = shadow_fill[COUNT_PORT_W-1:0];
        st.empty = (shadow_fill == 0);
        st.full  = (shadow_fill >= HPQ_CAPACITY);
        return st;
    endfunction

    // Pick a key: extremes, a narrow band for ties, or any pattern
    function automatic key_t pick_key();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(3))
                    0: return KEY_MAX;
                    1: return KEY_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
            1, 2, 3: return key_t'($urandom_range(16)) - key_t'(8);
            default: return key_t'($urandom);
        endcase
    endfunction

    // Offer one beat, wait for its acceptance and record the expected status
    task automatic send_beat(input logic op, input key_t key, input logic typed,
                             input heap_status_t want);
        heap_status_t st;
        steady = (n_sent >= STEADY_FROM && n_sent < STEADY_TO);
        if (n_sent == HOLD_AT)
            hold_req = 1'b1;
        if (n_sent == PAUSE_AT) begin
            in_valid <= 1'b0;
            while (pending_status.size() != 0)
                @(posedge clk);
        end
        if (!steady && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < IDLE_PCT);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        value    <= key;
        do
            @(posedge clk);
        while (!in_ready);
        st = heap_apply(op, key);
        pending_status.push_back(typed ? want : st);
        n_sent++;
        if (st.rej)
            n_rejects++;
        if (st.full && !st.rej)
            n_full_seen++;
        if (op == OP_DELETE && !st.rej)
            n_deletes++;
    endtask

    task automatic send_random(input int insert_pct);
        logic op;
        op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_DELETE;
        send_beat(op, pick_key(), 1'b0, '0);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("mismatch on result %0d, %s: expected %h, got %h",
                         n_checked, name, want, got);
        end
    endtask

    // Compare each returned beat with the oldest expectation
    always @(posedge clk) begin
        heap_status_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_status.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected result beat: removed %h top %h count %0d",
                             removed_value, top_value, entry_count);
            end
            else begin
                want = pending_status.pop_front();
                check_field("removed_value", want.removed, removed_value);
                check_field("top_value", want.top, top_value);
                check_field("entry_count", 32'(want.count), 32'(entry_count));
                check_field("is_empty", 32'(want.empty), 32'(is_empty));
                check_field("is_full", 32'(want.full), 32'(is_full));
                check_field("rejected", 32'(want.rej), 32'(rejected));
            end
            n_checked++;
        end
    end

    // Stop the run when nothing moves for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cnt <= 0;
        end
        else begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Receiver: random back-pressure, one long hold-off on request
    initial begin
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else begin
                out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        int phase;
        int extra;
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        opcode       = OP_INSERT;
        value        = '0;
        shadow_fill  = 0;
        mismatch_cnt = 0;
        n_sent       = 0;
        n_checked    = 0;
        n_rejects    = 0;
        n_full_seen  = 0;
        n_deletes    = 0;
        stall_cnt    = 0;
        hold_req     = 1'b0;
        steady       = 1'b0;

        // op, key, typed, {removed, top, count, empty, full, rejected}
        dir_rows = '{
            '{OP_DELETE, 32'sd0, 1'b1, '{32'sd0, 32'sd0, 7'd0, 1'b1, 1'b0, 1'b1}},
            '{OP_INSERT, 32'sd0, 1'b1, '{32'sd0, 32'sd0, 7'd1, 1'b0, 1'b0, 1'b0}},
            '{OP_INSERT, KEY_MIN, 1'b1, '{32'sd0, 32'sd0, 7'd2, 1'b0, 1'b0, 1'b0}},
            '{OP_INSERT, KEY_MAX, 1'b1, '{32'sd0, KEY_MAX, 7'd3, 1'b0, 1'b0, 1'b0}},
            '{OP_INSERT, -32'sd1, 1'b0, '0},
            '{OP_INSERT, 32'sd5, 1'b0, '0},
            '{OP_INSERT, 32'sd5, 1'b0, '0},
            '{OP_INSERT, 32'sd5, 1'b0, '0},
            '{OP_INSERT, KEY_MAX, 1'b0, '0},
            '{OP_INSERT, KEY_MAX - 1, 1'b0, '0},
            '{OP_DELETE, 32'sd0, 1'b1, '{KEY_MAX, KEY_MAX, 7'd8, 1'b0, 1'b0, 1'b0}},
            '{OP_DELETE, 32'sd0, 1'b1, '{KEY_MAX, KEY_MAX - 1, 7'd7, 1'b0, 1'b0, 1'b0}},
            '{OP_DELETE, 32'sd0, 1'b0, '0},
            '{OP_DELETE, 32'h5A5A_5A5A, 1'b0, '0},
            '{OP_DELETE, 32'hFFFF_FFFF, 1'b0, '0},
            '{OP_DELETE, 32'sd0, 1'b0, '0},
            '{OP_DELETE, 32'sd0, 1'b0, '0},
            '{OP_DELETE, 32'sd0, 1'b0, '0},
            '{OP_DELETE, 32'sd0, 1'b1, '{KEY_MIN, 32'sd0, 7'd0, 1'b1, 1'b0, 1'b0}},
            '{OP_DELETE, 32'sd0, 1'b1, '{32'sd0, 32'sd0, 7'd0, 1'b1, 1'b0, 1'b1}},
            '{OP_INSERT, -32'sd2, 1'b0, '0},
            '{OP_INSERT, 32'sd3, 1'b0, '0},
            '{OP_DELETE, 32'sd0, 1'b0, '0}
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows
        for (int i = 0; i < DIR_N; i++)
            send_beat(dir_rows[i].op, dir_rows[i].key, dir_rows[i].typed,
                      dir_rows[i].want);

        // random phases: fill past full, churn, drain past empty, churn
        phase = 0;
        while (n_sent < TOTAL_ITEMS) begin
            case (phase % 4)
                0: begin
                    while (shadow_fill < HPQ_CAPACITY)
                        send_random(85);
                    extra = $urandom_range(1, 5);
                    repeat (extra) send_random(90);
                end
                2: begin
                    while (shadow_fill > 0)
                        send_random(15);
                    extra = $urandom_range(1, 5);
                    repeat (extra) send_random(10);
                end
                default: begin
                    extra = $urandom_range(30, 120);
                    repeat (extra) send_random(50);
                end
            endcase
            phase++;
        end
        in_valid <= 1'b0;

        // wait for the last results, then let the block settle
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("sent %0d beats, checked %0d results, %0d mismatches",
                 n_sent, n_checked, mismatch_cnt);
        $display("%0d rejected operations, %0d deletes, heap reached capacity %0d times",
                 n_rejects, n_deletes, n_full_seen);
        if (mismatch_cnt == 0) begin
            $display("CHECK OK");
        end
        else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ max_heap_priority_queue.f @@
sv/hpq_pkg.sv
sv/hpq_ram.sv
sv/max_heap_priority_queue.sv
bench/tb_top.sv
